// ===== design/ufs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_pkg
// shared types and constants of the union-by-size disjoint-set engine
// ----------------------------------------------------------------------------
package ufs_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = 10;
  localparam int SIZE_W = 11;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_UNION = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic [SIZE_W-1:0] set_size;
    logic              merged;
  } out_item_t;

endpackage

// ===== design/union_find_by_size_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_by_size_core
// disjoint-set engine with union by size and full path compression
// ----------------------------------------------------------------------------
// usage
//   input channel  in_valid_i / in_stall_o / in_data_i   (opcode, node_a, node_b)
//   output channel out_valid_o / out_stall_i / out_data_o (root, set_size, merged)
//   a beat moves when valid is high and stall is low; every input beat gives
//   exactly one output beat, in order
//   the forest sits in two 1024-entry synchronous memories (parent, size)
//   sharing one read address
//   find: walk from the node to its root, then point each node on the path at it
//   union: a find of node_a, a find of node_b, then a link of the smaller set under the larger
//   the engine returns to idle as the result is registered, then takes the next beat
//   depth stays at or below 10 with union by size
//   clear: a sweep rewrites all 1024 entries of both memories, then the result
//   after reset the same sweep runs before the first beat is taken
//   one item is in work at a time; the result waits in an output register,
//   and while the receiver stalls the engine finishes one more item, holds it
//   and keeps the input stalled
// ----------------------------------------------------------------------------
module union_find_by_size_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ufs_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ufs_pkg::out_item_t out_data_o
);

  localparam int NW = ufs_pkg::NODE_W;
  localparam int SW = ufs_pkg::SIZE_W;

  // forest storage
  logic [NW-1:0] parent_mem [ufs_pkg::NODES];
  logic [SW-1:0] size_mem   [ufs_pkg::NODES];

  ufs_pkg::state_e state_q, state_d;

  // memory ports
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] prd_q;    // parent read data
  logic [SW-1:0] srd_q;    // size read data
  logic          pwe, swe;
  logic [NW-1:0] pwaddr, pwdata, swaddr;
  logic [SW-1:0] swdata;

  // walk context
  logic [NW-1:0] cur_q, cur_d;       // node being visited
  logic [NW-1:0] start_q, start_d;   // node the current find started at
  logic [NW-1:0] b_q, b_d;           // second node of a union
  logic          side_q, side_d;     // 0 while finding node_a, 1 for node_b
  logic          union_q, union_d;
  logic [NW-1:0] top_q, top_d;       // root of the current find
  logic [SW-1:0] tsize_q, tsize_d;   // size held at that root
  logic [NW-1:0] ra_q, ra_d;
  logic [SW-1:0] sa_q, sa_d;

  logic [NW-1:0] sweep_q, sweep_d;
  logic          pend_q, pend_d;     // a clear beat waits for its result

  ufs_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic          accept;
  logic          out_free;
  logic          sweep_last;
  logic [SW-1:0] sum;

  assign in_stall_o  = (state_q != ufs_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sweep_last  = (sweep_q == NW'(ufs_pkg::NODES - 1));
  assign sum         = sa_q + tsize_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ufs_pkg::ST_SWEEP: begin
        if (sweep_last) state_d = pend_q ? ufs_pkg::ST_DONE : ufs_pkg::ST_IDLE;
      end
      ufs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (ufs_pkg::op_e'(in_data_i.opcode))
            ufs_pkg::OP_FIND,
            ufs_pkg::OP_UNION: state_d = ufs_pkg::ST_WALK;
            ufs_pkg::OP_CLEAR: state_d = ufs_pkg::ST_SWEEP;
            default:           state_d = ufs_pkg::ST_DONE;
          endcase
        end
      end
      ufs_pkg::ST_WALK: begin
        if (prd_q == cur_q) state_d = ufs_pkg::ST_COMP;
      end
      ufs_pkg::ST_COMP: begin
        if (cur_q == top_q) begin
          if (side_q)       state_d = ufs_pkg::ST_LINK;
          else if (union_q) state_d = ufs_pkg::ST_WALK;
          else              state_d = ufs_pkg::ST_DONE;
        end
      end
      ufs_pkg::ST_LINK: state_d = ufs_pkg::ST_DONE;
      ufs_pkg::ST_DONE: begin
        if (out_free) state_d = ufs_pkg::ST_IDLE;
      end
      default: state_d = ufs_pkg::ST_SWEEP;
    endcase
  end

  // datapath and memory control
  always_comb begin
    rd_addr     = cur_q;
    pwe         = 1'b0;
    swe         = 1'b0;
    pwaddr      = cur_q;
    pwdata      = top_q;
    swaddr      = cur_q;
    swdata      = sum;
    cur_d       = cur_q;
    start_d     = start_q;
    b_d         = b_q;
    side_d      = side_q;
    union_d     = union_q;
    top_d       = top_q;
    tsize_d     = tsize_q;
    ra_d        = ra_q;
    sa_d        = sa_q;
    sweep_d     = sweep_q;
    pend_d      = pend_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ufs_pkg::ST_SWEEP: begin
        // every node back to a singleton root
        pwe     = 1'b1;
        swe     = 1'b1;
        pwaddr  = sweep_q;
        pwdata  = sweep_q;
        swaddr  = sweep_q;
        swdata  = SW'(1);
        sweep_d = sweep_q + NW'(1);
        if (sweep_last) pend_d = 1'b0;
      end
      ufs_pkg::ST_IDLE: begin
        rd_addr = in_data_i.node_a;
        if (accept) begin
          cur_d   = in_data_i.node_a;
          start_d = in_data_i.node_a;
          b_d     = in_data_i.node_b;
          side_d  = 1'b0;
          res_d   = '0;
          unique case (ufs_pkg::op_e'(in_data_i.opcode))
            ufs_pkg::OP_FIND:  union_d = 1'b0;
            ufs_pkg::OP_UNION: union_d = 1'b1;
            ufs_pkg::OP_CLEAR: begin
              sweep_d = '0;
              pend_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ufs_pkg::ST_WALK: begin
        if (prd_q == cur_q) begin
          // root reached; restart at the first node for compression
          top_d   = cur_q;
          tsize_d = srd_q;
          cur_d   = start_q;
          rd_addr = start_q;
        end else begin
          cur_d   = prd_q;
          rd_addr = prd_q;
        end
      end
      ufs_pkg::ST_COMP: begin
        if (cur_q == top_q) begin
          if (!side_q) begin
            ra_d  = top_q;
            sa_d  = tsize_q;
            res_d = '{root: top_q, set_size: tsize_q, merged: 1'b0};
            if (union_q) begin
              side_d  = 1'b1;
              cur_d   = b_q;
              start_d = b_q;
              rd_addr = b_q;
            end
          end
        end else begin
          // point this node at the root and move on to its old parent
          pwe     = 1'b1;
          pwaddr  = cur_q;
          pwdata  = top_q;
          cur_d   = prd_q;
          rd_addr = prd_q;
        end
      end
      ufs_pkg::ST_LINK: begin
        // top_q / tsize_q hold the root of node_b and its size
        if (ra_q == top_q) begin
          res_d = '{root: ra_q, set_size: sa_q, merged: 1'b0};
        end else if (sa_q < tsize_q) begin
          pwe    = 1'b1;
          pwaddr = ra_q;
          pwdata = top_q;
          swe    = 1'b1;
          swaddr = top_q;
          res_d  = '{root: top_q, set_size: sum, merged: 1'b1};
        end else begin
          pwe    = 1'b1;
          pwaddr = top_q;
          pwdata = ra_q;
          swe    = 1'b1;
          swaddr = ra_q;
          res_d  = '{root: ra_q, set_size: sum, merged: 1'b1};
        end
      end
      ufs_pkg::ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ufs_pkg::ST_SWEEP;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    start_q <= start_d;
    b_q     <= b_d;
    side_q  <= side_d;
    union_q <= union_d;
    top_q   <= top_d;
    tsize_q <= tsize_d;
    ra_q    <= ra_d;
    sa_q    <= sa_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // parent memory
  always_ff @(posedge clk_i) begin
    if (pwe) parent_mem[pwaddr] <= pwdata;
    prd_q <= parent_mem[rd_addr];
  end

  // size memory
  always_ff @(posedge clk_i) begin
    if (swe) size_mem[swaddr] <= swdata;
    srd_q <= size_mem[rd_addr];
  end

`ifndef SYNTH
  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ufs_pkg::ST_IDLE))
    else $error("accepted beat left the engine idle");

  // no memory writes while waiting for a new beat
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ufs_pkg::ST_IDLE) |-> (!pwe && !swe))
    else $error("memory write while idle");

  // compression never rewrites the root itself
  a_comp_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pwe && (state_q == ufs_pkg::ST_COMP)) |-> (pwaddr != top_q))
    else $error("compression wrote the root entry");

  // a new result only comes out of the done state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ufs_pkg::ST_DONE))
    else $error("result raised outside the done state");

  // a merge joins at least two elements
  a_merge_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.merged) |-> (out_data_o.set_size >= SW'(2)))
    else $error("merged set smaller than two");
`endif

endmodule

// ===== sim/union_find_by_size_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_by_size_core_test
// self-checking bench for the union-by-size disjoint-set engine: a short
// table of hand-picked beats, then random find, union, clear and void beats,
// partly in balanced tree builds; each result compared field by field against
// the table row or a software forest kept in step with every accepted beat
// ----------------------------------------------------------------------------
module union_find_by_size_core_test;

  typedef logic [ufs_pkg::NODE_W-1:0] node_t;
  typedef logic [ufs_pkg::SIZE_W-1:0] count_t;

  // opcode value with no operation behind it
  localparam logic [1:0] OP_VOID = 2'd3;

  localparam int RAND_ITEMS = 1150;
  localparam int DIR_ROWS   = 22;
  localparam int DRAIN_CYC  = 80;

  // one row of the directed table; want_* only counts when typed is set
  typedef struct packed {
    logic [1:0] op;
    node_t      a;
    node_t      b;
    bit         typed;
    node_t      want_root;
    count_t     want_size;
    logic       want_merged;
  } dir_row_t;

  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    // fresh forest: every node alone
    '{ufs_pkg::OP_FIND,  10'd0,    10'd0,    1'b1, 10'd0,    11'd1, 1'b0},
    '{ufs_pkg::OP_FIND,  10'd1023, 10'd1023, 1'b1, 10'd1023, 11'd1, 1'b0},
    // tie keeps the root of node_a
    '{ufs_pkg::OP_UNION, 10'd0,    10'd1023, 1'b1, 10'd0,    11'd2, 1'b1},
    // already joined
    '{ufs_pkg::OP_UNION, 10'd1023, 10'd0,    1'b1, 10'd0,    11'd2, 1'b0},
    '{ufs_pkg::OP_FIND,  10'd1023, 10'd0,    1'b1, 10'd0,    11'd2, 1'b0},
    // smaller set of node_a goes under node_b's root
    '{ufs_pkg::OP_UNION, 10'd512,  10'd0,    1'b1, 10'd0,    11'd3, 1'b1},
    '{ufs_pkg::OP_UNION, 10'd341,  10'd682,  1'b1, 10'd341,  11'd2, 1'b1},
    '{ufs_pkg::OP_UNION, 10'd682,  10'd1023, 1'b1, 10'd0,    11'd5, 1'b1},
    '{ufs_pkg::OP_FIND,  10'd682,  10'd1023, 1'b1, 10'd0,    11'd5, 1'b0},
    // unknown opcode leaves the forest alone and returns zeros
    '{OP_VOID,           10'd1023, 10'd1023, 1'b1, 10'd0,    11'd0, 1'b0},
    '{ufs_pkg::OP_FIND,  10'd341,  10'd0,    1'b1, 10'd0,    11'd5, 1'b0},
    // union of a node with itself
    '{ufs_pkg::OP_UNION, 10'd5,    10'd5,    1'b1, 10'd5,    11'd1, 1'b0},
    '{ufs_pkg::OP_CLEAR, 10'd0,    10'd0,    1'b1, 10'd0,    11'd0, 1'b0},
    '{ufs_pkg::OP_FIND,  10'd682,  10'd0,    1'b1, 10'd682,  11'd1, 1'b0},
    '{ufs_pkg::OP_UNION, 10'd1023, 10'd0,    1'b1, 10'd1023, 11'd2, 1'b1},
    '{ufs_pkg::OP_UNION, 10'd1,    10'd2,    1'b1, 10'd1,    11'd2, 1'b1},
    // small tree with a second level, left to the forest model
    '{ufs_pkg::OP_UNION, 10'd3,    10'd1,    1'b0, 10'd0,    11'd0, 1'b0},
    '{ufs_pkg::OP_UNION, 10'd4,    10'd5,    1'b0, 10'd0,    11'd0, 1'b0},
    '{ufs_pkg::OP_UNION, 10'd4,    10'd1,    1'b0, 10'd0,    11'd0, 1'b0},
    '{ufs_pkg::OP_FIND,  10'd5,    10'd0,    1'b0, 10'd0,    11'd0, 1'b0},
    // clear with nonzero node fields, then an unknown opcode on zeros
    '{ufs_pkg::OP_CLEAR, 10'd1023, 10'd1023, 1'b1, 10'd0,    11'd0, 1'b0},
    '{OP_VOID,           10'd0,    10'd0,    1'b1, 10'd0,    11'd0, 1'b0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ufs_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ufs_pkg::out_item_t out_data_o;

  union_find_by_size_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // software copy of the forest
  node_t  up_tbl  [ufs_pkg::NODES];
  count_t cnt_tbl [ufs_pkg::NODES];

  ufs_pkg::out_item_t pending_res [$];
  int                 mismatch_cnt = 0;
  int                 beats_sent   = 0;
  int                 calm_left    = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void forest_clear();
    for (int n = 0; n < ufs_pkg::NODES; n++) begin
      up_tbl[n]  = node_t'(n);
      cnt_tbl[n] = count_t'(1);
    end
  endfunction

  // walk to the root, then point every node on the path straight at it
  function automatic node_t forest_root(input node_t n);
    node_t top;
    node_t cur;
    node_t nxt;
    top = n;
    while (up_tbl[top] != top) top = up_tbl[top];
    cur = n;
    while (cur != top) begin
      nxt = up_tbl[cur];
      up_tbl[cur] = top;
      cur = nxt;
    end
    return top;
  endfunction

  function automatic ufs_pkg::out_item_t forest_apply(input ufs_pkg::in_item_t it);
    ufs_pkg::out_item_t res;
    node_t              ra;
    node_t              rb;
    res = '0;
    case (it.opcode)
      ufs_pkg::OP_FIND: begin
        ra = forest_root(it.node_a);
        res.root     = ra;
        res.set_size = cnt_tbl[ra];
      end
      ufs_pkg::OP_UNION: begin
        ra = forest_root(it.node_a);
        rb = forest_root(it.node_b);
        if (ra == rb) begin
          res.root     = ra;
          res.set_size = cnt_tbl[ra];
        end else if (cnt_tbl[ra] < cnt_tbl[rb]) begin
          up_tbl[ra]   = rb;
          cnt_tbl[rb]  = cnt_tbl[rb] + cnt_tbl[ra];
          res.root     = rb;
          res.set_size = cnt_tbl[rb];
          res.merged   = 1'b1;
        end else begin
          up_tbl[rb]   = ra;
          cnt_tbl[ra]  = cnt_tbl[ra] + cnt_tbl[rb];
          res.root     = ra;
          res.set_size = cnt_tbl[ra];
          res.merged   = 1'b1;
        end
      end
      ufs_pkg::OP_CLEAR: forest_clear();
      default: ;
    endcase
    return res;
  endfunction

  // present one beat at a falling edge, hold it until taken, then log
  // what should come back for it
  task automatic send_beat(input ufs_pkg::in_item_t it, input bit typed,
                           input ufs_pkg::out_item_t want);
    ufs_pkg::out_item_t model_res;
    int                 gap;
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(20, 80);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    model_res = forest_apply(it);
    pending_res.insert(pending_res.size(), typed ? want : model_res);
    beats_sent++;
  endtask

  task automatic send_op(input logic [1:0] op, input node_t a, input node_t b);
    ufs_pkg::in_item_t it;
    it.opcode = op;
    it.node_a = a;
    it.node_b = b;
    send_beat(it, 1'b0, '0);
  endtask

  // result side: compare every taken beat with the oldest expectation
  always @(posedge clk_i) begin : res_check
    ufs_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected beat, root", out_data_o.root, -1);
      end else begin
        want = pending_res.pop_front();
        if (out_data_o.root !== want.root)
          report_mismatch("root", out_data_o.root, want.root);
        if (out_data_o.set_size !== want.set_size)
          report_mismatch("set_size", out_data_o.set_size, want.set_size);
        if (out_data_o.merged !== want.merged)
          report_mismatch("merged", out_data_o.merged, want.merged);
      end
    end
  end

  // receiver back-pressure: quiet stretches mixed with random stalls
  initial begin : out_side
    int hold;
    out_stall_i = 1'b0;
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        hold = $urandom_range(30, 150);
        repeat (hold) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end else begin
        hold = pick_gap();
        repeat (hold) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold = pick_gap() + 1;
        repeat (hold) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // main sequence: reset, directed table, random traffic, drain
  initial begin : in_side
    ufs_pkg::in_item_t  it;
    ufs_pkg::out_item_t want;
    int                 pick;
    int                 k;
    int                 span;
    int                 base;
    int                 step;
    int                 i;
    int                 stop_at;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    forest_clear();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows; the engine stalls through its sweep after reset
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.opcode        = DIR_TBL[r].op;
      it.node_a        = DIR_TBL[r].a;
      it.node_b        = DIR_TBL[r].b;
      want.root        = DIR_TBL[r].want_root;
      want.set_size    = DIR_TBL[r].want_size;
      want.merged      = DIR_TBL[r].want_merged;
      send_beat(it, DIR_TBL[r].typed, want);
    end

    stop_at = beats_sent + RAND_ITEMS;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // balanced build over an aligned block: pairs, then pairs of pairs,
        // so tree depth grows with each level; operand order is random
        k    = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
        span = 1 << k;
        base = $urandom_range(0, (ufs_pkg::NODES >> k) - 1) << k;
        for (step = 1; step < span; step = step * 2) begin
          for (i = 0; i < span; i += 2 * step) begin
            if ($urandom_range(0, 1) == 1)
              send_op(ufs_pkg::OP_UNION, node_t'(base + i), node_t'(base + i + step));
            else
              send_op(ufs_pkg::OP_UNION, node_t'(base + i + step), node_t'(base + i));
          end
        end
        // probe leaves so the deep paths get walked and compressed
        repeat ($urandom_range(1, 4))
          send_op(ufs_pkg::OP_FIND, node_t'(base + $urandom_range(0, span - 1)),
                  node_t'($urandom()));
      end else if (pick < 45) begin
        send_op(ufs_pkg::OP_FIND, node_t'($urandom_range(0, 63)), node_t'($urandom()));
      end else if (pick < 65) begin
        send_op(ufs_pkg::OP_UNION, node_t'($urandom_range(0, 63)),
                node_t'($urandom_range(0, 63)));
      end else if (pick < 80) begin
        send_op(ufs_pkg::OP_UNION, node_t'($urandom()), node_t'($urandom()));
      end else if (pick < 96) begin
        send_op(ufs_pkg::OP_FIND, node_t'($urandom()), node_t'($urandom()));
      end else if (pick < 98) begin
        send_op(OP_VOID, node_t'($urandom()), node_t'($urandom()));
      end else begin
        // clear costs a full sweep, so keep it rare
        send_op(ufs_pkg::OP_CLEAR, node_t'($urandom()), node_t'($urandom()));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #8ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ufs_pkg.sv
design/union_find_by_size_core.sv
sim/union_find_by_size_core_test.sv
